[rtl/gregorian_date_day_adder_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Gregorian date day adder
// Shared helpers for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_DAY_ADDER_UNIT_DEFINES_SVH
`define GREGORIAN_DATE_DAY_ADDER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define GDDA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gdda same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define GDDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gdda next-cycle check failed");

`endif

[rtl/gdda_pkg.sv]
// ----------------------------------------------------------------------------
// gdda_pkg
// Types, constants and the month-length table for the date day adder.
// ----------------------------------------------------------------------------
package gdda_pkg;

	localparam int DAY_W    = 5;
	localparam int MONTH_W  = 4;
	localparam int YEAR_W   = 14;
	localparam int CHANGE_W = 11;
	localparam int DACC_W   = 12;	// running day count, signed
	localparam int CENT_W   = 8;	// year / 100
	localparam int REM_W    = 7;	// year % 100

	localparam logic [YEAR_W-1:0]  YEAR_MAX = 14'd9999;
	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
	localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
	localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
	localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	// year / 100 as (year * 5243) >> 19, exact for year <= 9999
	localparam logic [12:0] DIV100_RECIP = 13'd5243;
	localparam int          DIV100_SHIFT = 19;
	localparam logic [REM_W-1:0] REM_LAST = 7'd99;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_CHECK,
		ST_STEP,
		ST_PUBLISH
	} gdda_state_t;

	typedef struct packed {
		logic load;		// capture an input transfer
		logic calc_rem;	// form year % 100
		logic set_bad;	// mark result as echo of input
		logic step;		// move by one month
		logic publish;	// write output register
	} gdda_cmd_t;

	typedef struct packed {
		logic chk_bad;	// start date invalid
		logic need_fwd;	// day past end of current month
		logic need_bwd;	// day at or before zero
		logic wrap_bad;	// next step leaves the year range
	} gdda_status_t;

	// Days in month m; invalid months give 31 and are screened elsewhere
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		len = 5'd31;
		case (m) inside
			MONTH_FEB: len = leap ? 5'd29 : 5'd28;
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

[rtl/gdda_ctrl.sv]
// ----------------------------------------------------------------------------
// gdda_ctrl
// Sequencer: load, year split, date check, month stepping, result hand-off.
// ----------------------------------------------------------------------------
module gdda_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  gdda_pkg::gdda_status_t status,
	output gdda_pkg::gdda_cmd_t    cmd
);
	import gdda_pkg::*;

	gdda_state_t state_q, state_d;
	logic        out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.calc_rem = 1'b1;
				state_d      = ST_CHECK;
			end
			ST_CHECK: begin
				if (status.chk_bad) begin
					cmd.set_bad = 1'b1;
					state_d     = ST_PUBLISH;
				end else begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				if (status.wrap_bad) begin
					cmd.set_bad = 1'b1;
					state_d     = ST_PUBLISH;
				end else if (status.need_fwd || status.need_bwd) begin
					cmd.step = 1'b1;
				end else begin
					state_d = ST_PUBLISH;
				end
			end
			ST_PUBLISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

[rtl/gdda_datapath.sv]
// ----------------------------------------------------------------------------
// gdda_datapath
// Date registers, year split into century and remainder, month stepping.
// ----------------------------------------------------------------------------
module gdda_datapath (
	input  logic                                  clk,
	input  gdda_pkg::gdda_cmd_t                    cmd,
	output gdda_pkg::gdda_status_t                 status,
	input  logic [gdda_pkg::DAY_W-1:0]            day_in,
	input  logic [gdda_pkg::MONTH_W-1:0]          month_in,
	input  logic [gdda_pkg::YEAR_W-1:0]           year_in,
	input  logic signed [gdda_pkg::CHANGE_W-1:0]  day_change,
	output logic [gdda_pkg::DAY_W-1:0]            day_out,
	output logic [gdda_pkg::MONTH_W-1:0]          month_out,
	output logic [gdda_pkg::YEAR_W-1:0]           year_out,
	output logic                                  bad_date
);
	import gdda_pkg::*;

	// start date, kept for echo
	logic [DAY_W-1:0]   d0_q;
	logic [MONTH_W-1:0] m0_q;
	logic [YEAR_W-1:0]  y0_q;
	// working date
	logic signed [DACC_W-1:0] d_q;
	logic [MONTH_W-1:0]       m_q;
	logic [YEAR_W-1:0]        y_q;
	logic [CENT_W-1:0]        cent_q;
	logic [REM_W-1:0]         rem_q;
	logic                     bad_q;
	// output register
	logic [DAY_W-1:0]   day_out_q;
	logic [MONTH_W-1:0] month_out_q;
	logic [YEAR_W-1:0]  year_out_q;
	logic               bad_out_q;

	logic [26:0]              cent_prod;
	logic [YEAR_W:0]          cent_x100;
	logic [YEAR_W:0]          rem_full;
	logic                     leap;
	logic [MONTH_W-1:0]       m_prev;
	logic [DAY_W-1:0]         len_cur;
	logic [DAY_W-1:0]         len_prev;
	logic signed [DACC_W-1:0] len_cur_s;
	logic signed [DACC_W-1:0] len_prev_s;
	logic signed [DACC_W-1:0] d_start;

	// century by reciprocal multiply, remainder from registered century
	assign cent_prod = {13'b0, year_in} * {14'b0, DIV100_RECIP};
	assign cent_x100 = {{(YEAR_W+1-CENT_W){1'b0}}, cent_q} * 15'd100;
	assign rem_full  = {1'b0, y_q} - cent_x100;

	// leap: divisible by 4, and not by 100 unless by 400
	assign leap = (rem_q[1:0] == 2'b00) && ((rem_q != '0) || (cent_q[1:0] == 2'b00));

	assign m_prev     = (m_q == MONTH_JAN) ? MONTH_DEC : m_q - 4'd1;
	assign len_cur    = month_len(m_q, leap);
	assign len_prev   = month_len(m_prev, leap);	// December is 31 in any year
	assign len_cur_s  = $signed({{(DACC_W-DAY_W){1'b0}}, len_cur});
	assign len_prev_s = $signed({{(DACC_W-DAY_W){1'b0}}, len_prev});
	assign d_start    = $signed({{(DACC_W-DAY_W){1'b0}}, day_in})
		+ $signed({day_change[CHANGE_W-1], day_change});

	// status to the sequencer
	always_comb begin
		status          = '0;
		status.chk_bad  = (m0_q == '0) || (m0_q > MONTH_DEC) || (y0_q > YEAR_MAX)
			|| (d0_q == '0) || (d0_q > len_cur);
		status.need_fwd = (d_q > len_cur_s);
		status.need_bwd = (d_q <= $signed(12'sd0));
		status.wrap_bad = (status.need_fwd && (m_q == MONTH_DEC) && (y_q == YEAR_MAX))
			|| (!status.need_fwd && status.need_bwd && (m_q == MONTH_JAN) && (y_q == '0));
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			d0_q   <= day_in;
			m0_q   <= month_in;
			y0_q   <= year_in;
			d_q    <= d_start;
			m_q    <= month_in;
			y_q    <= year_in;
			cent_q <= cent_prod[DIV100_SHIFT +: CENT_W];
			bad_q  <= 1'b0;
		end else if (cmd.calc_rem) begin
			rem_q <= rem_full[REM_W-1:0];
		end else if (cmd.set_bad) begin
			bad_q <= 1'b1;
		end else if (cmd.step) begin
			if (status.need_fwd) begin
				// carry into the next month
				d_q <= d_q - len_cur_s;
				if (m_q == MONTH_DEC) begin
					m_q <= MONTH_JAN;
					y_q <= y_q + 14'd1;
					if (rem_q == REM_LAST) begin
						rem_q  <= '0;
						cent_q <= cent_q + 8'd1;
					end else begin
						rem_q <= rem_q + 7'd1;
					end
				end else begin
					m_q <= m_q + 4'd1;
				end
			end else begin
				// borrow from the previous month
				d_q <= d_q + len_prev_s;
				m_q <= m_prev;
				if (m_q == MONTH_JAN) begin
					y_q <= y_q - 14'd1;
					if (rem_q == '0) begin
						rem_q  <= REM_LAST;
						cent_q <= cent_q - 8'd1;
					end else begin
						rem_q <= rem_q - 7'd1;
					end
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			day_out_q   <= bad_q ? d0_q : d_q[DAY_W-1:0];
			month_out_q <= bad_q ? m0_q : m_q;
			year_out_q  <= bad_q ? y0_q : y_q;
			bad_out_q   <= bad_q;
		end
	end

	assign day_out   = day_out_q;
	assign month_out = month_out_q;
	assign year_out  = year_out_q;
	assign bad_date  = bad_out_q;

endmodule

[rtl/gregorian_date_day_adder_unit.sv]
// ----------------------------------------------------------------------------
// gregorian_date_day_adder_unit
// Adds a signed day offset to a Gregorian date, one month per cycle.
//
//   channel  signals                                       direction
//   in       in_valid/in_ready, day_in month_in year_in    into block
//            day_change
//   out      out_valid/out_ready, day_out month_out        out of block
//            year_out bad_date
//
// One item at a time: load, year split and date check, then one month step per
// month crossed, then the hand-off to the output register.
// The output register lets a new transfer in while a result waits.
// Reset clears the sequencer and the output valid flag; no sweep.
// A stalled output holds the sequencer in its hand-off state.
// ----------------------------------------------------------------------------
`include "gregorian_date_day_adder_unit_defines.svh"

module gregorian_date_day_adder_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [gdda_pkg::DAY_W-1:0]            day_in,
	input  logic [gdda_pkg::MONTH_W-1:0]          month_in,
	input  logic [gdda_pkg::YEAR_W-1:0]           year_in,
	input  logic signed [gdda_pkg::CHANGE_W-1:0]  day_change,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [gdda_pkg::DAY_W-1:0]            day_out,
	output logic [gdda_pkg::MONTH_W-1:0]          month_out,
	output logic [gdda_pkg::YEAR_W-1:0]           year_out,
	output logic                                  bad_date
);
	import gdda_pkg::*;

	gdda_cmd_t    cmd;
	gdda_status_t status;

	// sequencer
	gdda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// date datapath
	gdda_datapath u_datapath (
		.clk        (clk),
		.cmd        (cmd),
		.status     (status),
		.day_in     (day_in),
		.month_in   (month_in),
		.year_in    (year_in),
		.day_change (day_change),
		.day_out    (day_out),
		.month_out  (month_out),
		.year_out   (year_out),
		.bad_date   (bad_date)
	);

	// checks
	`GDDA_ASSERT_NEXT(a_busy_after_transfer, clk, arst_n, in_valid && in_ready, !in_ready)
	`GDDA_ASSERT_SAME(a_good_month_range, clk, arst_n, out_valid && !bad_date, (month_out != 4'd0) && (month_out <= MONTH_DEC))
	`GDDA_ASSERT_SAME(a_good_day_nonzero, clk, arst_n, out_valid && !bad_date, (day_out != 5'd0) && (year_out <= YEAR_MAX))
	`GDDA_ASSERT_SAME(a_one_command, clk, arst_n, 1'b1, $onehot0(cmd))

endmodule

[tb/sv/tb_gregorian_date_day_adder_unit.sv]
// ----------------------------------------------------------------------------
// Testbench for the Gregorian date day adder
// Drives dates and signed day offsets through the input channel, predicts
// each resulting date with a leap-aware month stepper and checks every
// output transfer in order. Covers invalid dates, year range limits and
// leap rules. Uses random bursts and gaps on the input, random stalls on
// the output, and one long output hold-off that back-pressures the input.
// ----------------------------------------------------------------------------
module tb_gregorian_date_day_adder_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import gdda_pkg::*;

	localparam int RESET_CYCLES  = 10;
	localparam int RANDOM_ITEMS  = 1200;
	localparam int DRAIN_CYCLES  = 60;
	localparam int HOLD_CYCLES   = 500;
	localparam int HOLD_AT       = 200;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int FIRST_YEAR    = 0;

	typedef struct packed {
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
		logic               bad;
	} date_result_t;

	// ------------------------------------------------------------------------
	// Scoreboard: predicts shifted dates and checks them in arrival order
	// ------------------------------------------------------------------------
	class date_scoreboard;
		date_result_t expected_dates[$];
		int           errors;

		function new();
			errors = 0;
		endfunction

		function int days_in_month(int m, int y);
			bit leap;
			leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
			if (m == MONTH_FEB)
				return leap ? 29 : 28;
			if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
				return 30;
			return 31;
		endfunction

		// Month-by-month stepping; an invalid start or a year out of range echoes the input
		function date_result_t shifted_date(logic [DAY_W-1:0] d0, logic [MONTH_W-1:0] m0,
				logic [YEAR_W-1:0] y0, logic signed [CHANGE_W-1:0] chg);
			date_result_t r;
			int d, m, y;
			bit bad;
			d = int'(d0);
			m = int'(m0);
			y = int'(y0);
			bad = 1'b0;
			if (m0 < MONTH_JAN || m0 > MONTH_DEC || y0 > YEAR_MAX) begin
				bad = 1'b1;
			end else if (d < 1 || d > days_in_month(m, y)) begin
				bad = 1'b1;
			end else begin
				d = d + int'(chg);
				while (!bad && d > days_in_month(m, y)) begin
					d = d - days_in_month(m, y);
					m++;
					if (m == int'(MONTH_DEC) + 1) begin
						m = int'(MONTH_JAN);
						y++;
						if (y > int'(YEAR_MAX))
							bad = 1'b1;
					end
				end
				while (!bad && d <= 0) begin
					m--;
					if (m == 0) begin
						m = int'(MONTH_DEC);
						y--;
					end
					if (y < FIRST_YEAR)
						bad = 1'b1;
					else
						d = d + days_in_month(m, y);
				end
			end
			if (bad) begin
				r.day   = d0;
				r.month = m0;
				r.year  = y0;
			end else begin
				r.day   = DAY_W'(d);
				r.month = MONTH_W'(m);
				r.year  = YEAR_W'(y);
			end
			r.bad = bad;
			return r;
		endfunction

		function void note_input(logic [DAY_W-1:0] d, logic [MONTH_W-1:0] m,
				logic [YEAR_W-1:0] y, logic signed [CHANGE_W-1:0] chg);
			expected_dates.push_back(shifted_date(d, m, y, chg));
		endfunction

		function void check_result(date_result_t got);
			date_result_t want;
			if (expected_dates.size() == 0) begin
				$error("result transfer with no date expected");
				errors++;
				return;
			end
			want = expected_dates.pop_front();
			if (got.day !== want.day) begin
				$error("day_out mismatch: expected %0d, actual %0d", want.day, got.day);
				errors++;
			end
			if (got.month !== want.month) begin
				$error("month_out mismatch: expected %0d, actual %0d", want.month, got.month);
				errors++;
			end
			if (got.year !== want.year) begin
				$error("year_out mismatch: expected %0d, actual %0d", want.year, got.year);
				errors++;
			end
			if (got.bad !== want.bad) begin
				$error("bad_date mismatch: expected %0d, actual %0d", want.bad, got.bad);
				errors++;
			end
		endfunction

		function int pending();
			return expected_dates.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Signals and block
	// ------------------------------------------------------------------------
	logic                       clk        = 1'b0;
	logic                       arst_n     = 1'b0;
	logic                       in_valid   = 1'b0;
	logic                       in_ready;
	logic [DAY_W-1:0]           day_in     = '0;
	logic [MONTH_W-1:0]         month_in   = '0;
	logic [YEAR_W-1:0]          year_in    = '0;
	logic signed [CHANGE_W-1:0] day_change = '0;
	logic                       out_valid;
	logic                       out_ready  = 1'b0;
	logic [DAY_W-1:0]           day_out;
	logic [MONTH_W-1:0]         month_out;
	logic [YEAR_W-1:0]          year_out;
	logic                       bad_date;

	date_scoreboard sb = new();
	int             results_seen = 0;
	int             cycle_count  = 0;
	int             burst_left   = 0;

	gregorian_date_day_adder_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.day_in     (day_in),
		.month_in   (month_in),
		.year_in    (year_in),
		.day_change (day_change),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.day_out    (day_out),
		.month_out  (month_out),
		.year_out   (year_out),
		.bad_date   (bad_date)
	);

	// Clock
	always #5 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Transfer monitor: values seen here are those present before the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_input(day_in, month_in, year_in, day_change);
			if (out_valid && out_ready) begin
				sb.check_result('{day: day_out, month: month_out, year: year_out,
					bad: bad_date});
				results_seen <= results_seen + 1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sender: bursts of transfers separated by random gaps
	// ------------------------------------------------------------------------
	task automatic offer(input int d, input int m, input int y, input int chg);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			// mostly short bursts, now and then a long unbroken run
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		burst_left--;
		in_valid   <= 1'b1;
		day_in     <= DAY_W'(d);
		month_in   <= MONTH_W'(m);
		year_in    <= YEAR_W'(y);
		day_change <= CHANGE_W'(chg);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Random date: mostly valid, with a share of malformed and raw items
	task automatic offer_random_date();
		int d, m, y, chg, len, pick;
		pick = $urandom_range(0, 99);
		case ($urandom_range(0, 9))
			0: y = $urandom_range(0, 2);
			1: y = $urandom_range(int'(YEAR_MAX) - 2, int'(YEAR_MAX));
			2: y = 100 * $urandom_range(0, 99);
			default: y = $urandom_range(0, int'(YEAR_MAX));
		endcase
		m   = $urandom_range(int'(MONTH_JAN), int'(MONTH_DEC));
		len = sb.days_in_month(m, y);
		case ($urandom_range(0, 9))
			0: d = 1;
			1: d = len;
			default: d = $urandom_range(1, len);
		endcase
		case ($urandom_range(0, 6))
			0: chg = ($urandom_range(0, 1) == 1) ? 1023 : -1024;
			1: chg = $urandom_range(0, 80) - 40;
			default: chg = $urandom_range(0, 2047) - 1024;
		endcase
		if (pick < 8) begin
			// raw noise across every field bit
			d = $urandom_range(0, 31);
			m = $urandom_range(0, 15);
			y = $urandom_range(0, 16383);
		end else if (pick < 12) begin
			// day past the end of the month, or day zero
			d = (len == 31 || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(len + 1, 31);
		end else if (pick < 15) begin
			m = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 15);
		end
		offer(d, m, y, chg);
	endtask

	// ------------------------------------------------------------------------
	// Receiver: stall patterns plus one long hold-off
	// ------------------------------------------------------------------------
	initial begin
		int  mode;
		int  left;
		int  phase;
		bit  held;
		mode  = 0;
		left  = 0;
		phase = 0;
		held  = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			@(posedge clk);
			if (!held && results_seen >= HOLD_AT) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(30, 300);
			end
			left--;
			phase++;
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= (phase % 3 != 0);
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Reset, stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed cases
		offer(15, 6, 2024, 0);          // zero offset
		offer(31, 12, 9999, 1);         // result past the last year
		offer(1, 1, 0, -1);             // result before year zero
		offer(29, 2, 2000, 1);          // leap by 400
		offer(29, 2, 1900, 0);          // century, not leap: invalid day
		offer(28, 2, 1900, 1);
		offer(29, 2, 0, 0);             // year zero is leap
		offer(0, 5, 2020, 3);           // day zero
		offer(31, 4, 2021, 1);          // day past a 30-day month
		offer(10, 0, 2020, 5);          // month zero
		offer(10, 13, 2020, 5);         // month above December
		offer(31, 15, 16383, -1024);    // every date field at its top
		offer(1, 1, 10000, 0);          // start year out of range
		offer(1, 1, 9999, 1023);
		offer(31, 12, 9999, -1024);
		offer(1, 1, 0, 1023);
		offer(1, 3, 2024, -1);          // back into a leap February
		offer(1, 3, 2100, -1);          // back into a common February
		offer(31, 12, 2023, 1);         // year carry
		offer(1, 1, 1, -1);             // year borrow into year zero
		offer(31, 1, 2024, 29);
		offer(0, 0, 0, 0);

		repeat (RANDOM_ITEMS) offer_random_date();
		in_valid <= 1'b0;

		// drain; one edge first so the last input transfer is on the scoreboard
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/gdda_pkg.sv
rtl/gdda_ctrl.sv
rtl/gdda_datapath.sv
rtl/gregorian_date_day_adder_unit.sv
tb/sv/tb_gregorian_date_day_adder_unit.sv
